### rtl/prp_pkg.sv
package prp_pkg;

  localparam int PAT_LEN     = 16;
  localparam int IDX_W       = 4;
  localparam int LEN_W       = 5;
  localparam int VAL_W       = 48;
  localparam int MAX_PREDICT = 64;
  localparam int CNT_W       = 7;
  localparam int STRIDE_W    = 16;
  localparam int RPT_W       = 16;
  localparam int STEP_W      = 22;
  localparam int SEQ_W       = 6;
  localparam int OP_W        = 2;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int REG_IDX_W   = 3;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 96;

  localparam logic [OP_W-1:0] OP_LOAD_OFF = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_LEN = 2'd1;
  localparam logic [OP_W-1:0] OP_PREDICT  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BASE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_REPEAT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_SEQLEN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_BASE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_REPEAT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_SEQLEN = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SUM,
    PH_MUL,
    PH_DIV,
    PH_REM,
    PH_FIN,
    PH_EMIT
  } prp_phase_e;

  typedef struct packed {
    logic [VAL_W-1:0] offset_base;
    logic [RPT_W-1:0] offset_repeat_count;
    logic [LEN_W-1:0] offset_seq_len;
    logic [VAL_W-1:0] length_base;
    logic [RPT_W-1:0] length_repeat_count;
    logic [LEN_W-1:0] length_seq_len;
  } prp_cfg_t;

  typedef struct packed {
    prp_phase_e phase;
  } prp_cmd_t;

  typedef struct packed {
    logic single;
    logic done;
  } prp_status_t;

endpackage

### rtl/prp_regs.sv
module prp_regs
  import prp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output prp_cfg_t          cfg_o
);

  prp_cfg_t cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_base         <= '0;
      cfg_q.offset_repeat_count <= '0;
      cfg_q.offset_seq_len      <= '0;
      cfg_q.length_base         <= '0;
      cfg_q.length_repeat_count <= RPT_W'(1);
      cfg_q.length_seq_len      <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_OFFSET_BASE:   cfg_q.offset_base         <= pwdata[VAL_W-1:0];
        REG_OFFSET_REPEAT: cfg_q.offset_repeat_count <= pwdata[RPT_W-1:0];
        REG_OFFSET_SEQLEN: cfg_q.offset_seq_len      <= pwdata[LEN_W-1:0];
        REG_LENGTH_BASE:   cfg_q.length_base         <= pwdata[VAL_W-1:0];
        REG_LENGTH_REPEAT: cfg_q.length_repeat_count <= pwdata[RPT_W-1:0];
        REG_LENGTH_SEQLEN: cfg_q.length_seq_len      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OFFSET_BASE:   prdata = DATA_W'(cfg_q.offset_base);
      REG_OFFSET_REPEAT: prdata = DATA_W'(cfg_q.offset_repeat_count);
      REG_OFFSET_SEQLEN: prdata = DATA_W'(cfg_q.offset_seq_len);
      REG_LENGTH_BASE:   prdata = DATA_W'(cfg_q.length_base);
      REG_LENGTH_REPEAT: prdata = DATA_W'(cfg_q.length_repeat_count);
      REG_LENGTH_SEQLEN: prdata = DATA_W'(cfg_q.length_seq_len);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/prp_ctrl.sv
module prp_ctrl
  import prp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  input  prp_status_t     status_i,
  output logic            in_ready_o,
  output prp_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_DIV,
    S_REM,
    S_FIN,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic       ready_q;
  prp_phase_e phase_q;

  assign in_ready_o   = ready_q;
  assign cmd_o.phase  = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      phase_q <= PH_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q && in_op_i == OP_PREDICT) begin
            ready_q <= 1'b0;
            if (status_i.single) begin
              state_q <= S_MUL;
              phase_q <= PH_MUL;
            end else begin
              state_q <= S_SUM;
              phase_q <= PH_SUM;
            end
          end
        end
        S_SUM: begin
          if (status_i.done) begin
            state_q <= S_MUL;
            phase_q <= PH_MUL;
          end
        end
        S_MUL: begin
          if (status_i.done) begin
            if (status_i.single) begin
              state_q <= S_EMIT;
              phase_q <= PH_EMIT;
            end else begin
              state_q <= S_DIV;
              phase_q <= PH_DIV;
            end
          end
        end
        S_DIV: begin
          if (status_i.done) begin
            state_q <= S_REM;
            phase_q <= PH_REM;
          end
        end
        S_REM: begin
          if (status_i.done) begin
            state_q <= S_FIN;
            phase_q <= PH_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_EMIT;
          phase_q <= PH_EMIT;
        end
        S_EMIT: begin
          if (status_i.done) begin
            state_q <= S_IDLE;
            phase_q <= PH_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          phase_q <= PH_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/prp_dp.sv
module prp_dp
  import prp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prp_cfg_t            cfg_i,
  input  logic                in_accept_i,
  input  logic [OP_W-1:0]     in_op_i,
  input  logic [IDX_W-1:0]    in_slot_i,
  input  logic [VAL_W-1:0]    in_delta_i,
  input  logic [CNT_W-1:0]    in_count_i,
  input  logic [STRIDE_W-1:0] in_stride_i,
  input  prp_cmd_t            cmd_i,
  output prp_status_t         status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [VAL_W-1:0]    out_offset_o,
  output logic [VAL_W-1:0]    out_length_o,
  output logic                out_last_o
);

  logic [VAL_W-1:0] od_q [PAT_LEN];
  logic [VAL_W-1:0] ld_q [PAT_LEN];

  logic [CNT_W-1:0]  n_q, n_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [SEQ_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  r_q, r_d;
  logic [IDX_W-1:0]  jo_q, jo_d, jl_q, jl_d;
  logic [VAL_W-1:0]  osum_q, osum_d, lsum_q, lsum_d;
  logic [VAL_W-1:0]  acc_o_q, acc_o_d, acc_l_q, acc_l_d;
  logic [VAL_W-1:0]  boff_q, boff_d, blen_q, blen_d;
  logic              out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [VAL_W-1:0]  out_off_q, out_off_d, out_len_q, out_len_d;

  logic [LEN_W-1:0]  osl, lsl;
  logic              single, short_run, done;
  logic              predict_acc;
  logic [CNT_W-1:0]  n_sat;
  logic [STRIDE_W-1:0] stride_m1;
  logic [STRIDE_W+CNT_W-1:0] steps_full;
  logic [IDX_W-1:0]  od_idx, ld_idx;
  logic [VAL_W-1:0]  od_rd, ld_rd;
  logic [VAL_W-1:0]  mul_o, mul_l;
  logic [LEN_W:0]    rr;
  logic              q_bit;
  logic              emit_fire, emit_last;
  logic [IDX_W-1:0]  jo_inc, jl_inc;

  assign osl = (cfg_i.offset_seq_len > LEN_W'(PAT_LEN)) ? LEN_W'(PAT_LEN)
                                                        : cfg_i.offset_seq_len;
  assign lsl = (cfg_i.length_seq_len > LEN_W'(PAT_LEN)) ? LEN_W'(PAT_LEN)
                                                        : cfg_i.length_seq_len;

  assign single = (osl == '0) || (cfg_i.offset_repeat_count == '0) ||
                  (osl == LEN_W'(1) && cfg_i.offset_repeat_count == RPT_W'(1));
  assign short_run = (lsl == '0) || (n_q <= CNT_W'(1));

  assign predict_acc = in_accept_i && in_op_i == OP_PREDICT;
  assign n_sat = (in_count_i > CNT_W'(MAX_PREDICT)) ? CNT_W'(MAX_PREDICT) : in_count_i;
  assign stride_m1 = (in_stride_i == '0) ? '0 : in_stride_i - STRIDE_W'(1);
  assign steps_full = (STRIDE_W+CNT_W)'(stride_m1) * (STRIDE_W+CNT_W)'(n_sat);

  assign od_idx = (cmd_i.phase == PH_EMIT) ? jo_q : cnt_q[IDX_W-1:0];
  assign ld_idx = (cmd_i.phase == PH_SUM) ? cnt_q[IDX_W-1:0] : jl_q;
  assign od_rd  = od_q[od_idx];
  assign ld_rd  = ld_q[ld_idx];

  assign jo_inc = (LEN_W'(jo_q) + LEN_W'(1) == osl) ? '0 : jo_q + IDX_W'(1);
  assign jl_inc = (LEN_W'(jl_q) + LEN_W'(1) == lsl) ? '0 : jl_q + IDX_W'(1);

  assign emit_fire = (cmd_i.phase == PH_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last = single || short_run || (CNT_W'(cnt_q) + CNT_W'(1) == n_q);

  assign rr    = {r_q, steps_q[LEN_W'(STEP_W-1) - cnt_q[LEN_W-1:0]]};
  assign q_bit = rr >= {1'b0, osl};

  always_comb begin
    case (cmd_i.phase)
      PH_SUM:  done = cnt_q == SEQ_W'(PAT_LEN-1);
      PH_MUL:  done = single ? (cnt_q == SEQ_W'(CNT_W-1)) : (cnt_q == SEQ_W'(RPT_W-1));
      PH_DIV:  done = cnt_q == SEQ_W'(STEP_W-1);
      PH_REM:  done = cnt_q == SEQ_W'(PAT_LEN-1);
      PH_FIN:  done = 1'b1;
      PH_EMIT: done = emit_fire && emit_last;
      default: done = 1'b0;
    endcase
  end

  assign status_o.single = single;
  assign status_o.done   = done;

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_op_i == OP_LOAD_OFF) begin
      od_q[in_slot_i] <= in_delta_i;
    end
    if (in_accept_i && in_op_i == OP_LOAD_LEN) begin
      ld_q[in_slot_i] <= in_delta_i;
    end
  end

  always_comb begin
    n_d         = n_q;
    steps_d     = steps_q;
    cnt_d       = cnt_q;
    r_d         = r_q;
    jo_d        = jo_q;
    jl_d        = jl_q;
    osum_d      = osum_q;
    lsum_d      = lsum_q;
    acc_o_d     = acc_o_q;
    acc_l_d     = acc_l_q;
    boff_d      = boff_q;
    blen_d      = blen_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    mul_o       = '0;
    mul_l       = '0;

    if (predict_acc) begin
      n_d     = n_sat;
      steps_d = steps_full[STEP_W-1:0];
      cnt_d   = '0;
      r_d     = '0;
      jo_d    = '0;
      jl_d    = '0;
      osum_d  = '0;
      lsum_d  = '0;
      acc_o_d = '0;
      acc_l_d = '0;
    end

    case (cmd_i.phase)
      PH_SUM: begin
        if (cnt_q < SEQ_W'(osl)) osum_d = osum_q + od_rd;
        if (cnt_q < SEQ_W'(lsl)) lsum_d = lsum_q + ld_rd;
        cnt_d = done ? '0 : cnt_q + SEQ_W'(1);
      end
      PH_MUL: begin
        if (single) begin
          mul_l = {acc_l_q[VAL_W-2:0], 1'b0} +
                  (n_q[3'(CNT_W-1) - cnt_q[2:0]] ? cfg_i.length_base : '0);
          acc_l_d = mul_l;
          if (done) begin
            boff_d = cfg_i.offset_base + cfg_i.length_base;
            blen_d = mul_l;
          end
        end else begin
          mul_o = {acc_o_q[VAL_W-2:0], 1'b0} +
                  (cfg_i.offset_repeat_count[~cnt_q[IDX_W-1:0]] ? osum_q : '0);
          mul_l = {acc_l_q[VAL_W-2:0], 1'b0} +
                  (cfg_i.length_repeat_count[~cnt_q[IDX_W-1:0]] ? lsum_q : '0);
          acc_o_d = mul_o;
          acc_l_d = mul_l;
          if (done) begin
            boff_d  = cfg_i.offset_base + mul_o;
            blen_d  = cfg_i.length_base + mul_l;
            acc_o_d = '0;
            acc_l_d = '0;
          end
        end
        cnt_d = done ? '0 : cnt_q + SEQ_W'(1);
      end
      PH_DIV: begin
        r_d     = q_bit ? LEN_W'(rr - {1'b0, osl}) : rr[LEN_W-1:0];
        acc_o_d = {acc_o_q[VAL_W-2:0], 1'b0} + (q_bit ? osum_q : '0);
        acc_l_d = {acc_l_q[VAL_W-2:0], 1'b0} + (q_bit ? lsum_q : '0);
        cnt_d   = done ? '0 : cnt_q + SEQ_W'(1);
      end
      PH_REM: begin
        if (cnt_q < SEQ_W'(r_q)) begin
          acc_o_d = acc_o_q + od_rd;
          if (lsl != '0) begin
            acc_l_d = acc_l_q + ld_rd;
            jl_d    = jl_inc;
          end
        end
        cnt_d = done ? '0 : cnt_q + SEQ_W'(1);
      end
      PH_FIN: begin
        boff_d = boff_q + acc_o_q;
        blen_d = blen_q + acc_l_q;
        jo_d   = '0;
        jl_d   = '0;
      end
      PH_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_off_d   = boff_q;
          out_len_d   = blen_q;
          out_last_d  = emit_last;
          if (emit_last) begin
            cnt_d = '0;
          end else begin
            boff_d = boff_q + od_rd;
            blen_d = blen_q + ld_rd;
            jo_d   = jo_inc;
            jl_d   = jl_inc;
            cnt_d  = cnt_q + SEQ_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    steps_q    <= steps_d;
    r_q        <= r_d;
    jo_q       <= jo_d;
    jl_q       <= jl_d;
    osum_q     <= osum_d;
    lsum_q     <= lsum_d;
    acc_o_q    <= acc_o_d;
    acc_l_q    <= acc_l_d;
    boff_q     <= boff_d;
    blen_q     <= blen_d;
    out_off_q  <= out_off_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_offset_o = out_off_q;
  assign out_length_o = out_len_q;
  assign out_last_o   = out_last_q;

endmodule

### rtl/pattern_request_predictor_top.sv
// Stride pattern request predictor. Load transactions (tuser 0 or 1) write one
// delta into the offset or length table. A predict transaction (tuser 2)
// produces count result transactions, count capped at 64, or a single one when
// count is at most one, when the length table is empty or when the offset
// pattern holds a single request; tlast marks the final one and other tuser
// codes are dropped. The serial datapath sums both tables, does a shift-add
// multiply by the repeat counts, a restoring division of the step count by the
// offset sequence length and a pass over the remainder deltas, combines, then
// gives one result per cycle while the output is not stalled. A single-request
// pattern goes straight to a multiply and gives one result. The input is held
// off while a predict runs.
// Configuration registers sit at byte address 8*index on the APB port; the user
// must write them only while the block is idle, as the block itself does not
// enforce it. Tables are not initialized at reset.
module pattern_request_predictor_top
  import prp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[3:0], delta_value[51:4], count[58:52], start_stride[74:59], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pred_offset[47:0], pred_length[95:48]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  prp_cfg_t    cfg;
  prp_cmd_t    cmd;
  prp_status_t status;
  logic        in_accept;
  logic [VAL_W-1:0] out_offset, out_length;

  assign in_accept = s_axis_tvalid & s_axis_tready;

  prp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  prp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_accept_i  (in_accept),
    .in_op_i      (s_axis_tuser),
    .in_slot_i    (s_axis_tdata[IDX_W-1:0]),
    .in_delta_i   (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .in_count_i   (s_axis_tdata[IDX_W+VAL_W+CNT_W-1:IDX_W+VAL_W]),
    .in_stride_i  (s_axis_tdata[IDX_W+VAL_W+CNT_W+STRIDE_W-1:IDX_W+VAL_W+CNT_W]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_offset_o (out_offset),
    .out_length_o (out_length),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_length, out_offset};

endmodule
